// File: design/wavhp_pkg.sv
// Shared types and constants for the WAV header parser.
`default_nettype none

package wavhp_pkg;

    // One byte of the incoming file stream.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } item_t;

    // One result request: header, payload byte or reject.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [1:0]  sample_format;
        logic [31:0] rate_hz;
        logic [31:0] data_size;
        logic [7:0]  payload_byte;
        logic        last_payload;
    } result_t;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_EARLY_END   = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE    = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM     = 3'd3;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd4;

    // Four-character codes, little-endian as they arrive.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_PCM   = 32'h0000_0001;
    localparam logic [2:0]  AVG_LAST  = 3'd5;
    localparam logic [31:0] BITS_8    = 32'd8;
    localparam logic [31:0] BITS_16   = 32'd16;
    localparam logic [15:0] CHAN_MONO = 16'd1;
    localparam logic [15:0] CHAN_STEREO = 16'd2;

    // Result queue between the parser and the output side.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Parser phases.
    typedef enum logic [3:0] {
        PH_RIFF_HDR  = 4'd0,
        PH_RIFF_SKIP = 4'd1,
        PH_WAVE      = 4'd2,
        PH_FMT_HDR   = 4'd3,
        PH_FMT_SKIP  = 4'd4,
        PH_TAG       = 4'd5,
        PH_CHAN      = 4'd6,
        PH_RATE      = 4'd7,
        PH_AVG       = 4'd8,
        PH_BITS      = 4'd9,
        PH_FMT_TAIL  = 4'd10,
        PH_DATA_HDR  = 4'd11,
        PH_DATA_SKIP = 4'd12,
        PH_PAYLOAD   = 4'd13,
        PH_DONE      = 4'd14
    } phase_t;

endpackage

`default_nettype wire

// File: design/wavhp_parser.sv
// Front end: byte-at-a-time RIFF/WAVE chunk parser that classifies each byte.
`default_nettype none

module wavhp_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire wavhp_pkg::item_t item,
    output logic                  res_valid,
    output wavhp_pkg::result_t    res
);
    import wavhp_pkg::*;

    function automatic logic [31:0] put_byte(input logic [31:0] base, input logic [7:0] b,
                                             input logic [1:0] lane);
        put_byte = base | ({24'd0, b} << {lane, 3'b000});
    endfunction

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] fmt_rem_reg, fmt_rem_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [1:0]  format_reg, format_next;
    logic [31:0] pay_rem_reg, pay_rem_next;

    logic [31:0] hdr_tag, hdr_shift, fld_shift, skip_dec, pay_dec;
    logic        hdr_done;
    logic [1:0]  fc;
    logic [2:0]  fld_cnt_inc;
    logic [7:0]  b;
    logic        eos;
    logic        ch_ok, bits_ok;

    always_comb
    begin
        b   = item.in_byte;
        eos = item.end_of_stream;

        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        tag_next     = tag_reg;
        skip_next    = skip_reg;
        chan_next    = chan_reg;
        rate_next    = rate_reg;
        format_next  = format_reg;
        pay_rem_next = pay_rem_reg;
        res_valid    = 1'b0;
        res          = '0;

        // The fmt body counter runs down while its fixed fields are read.
        fmt_rem_next = fmt_rem_reg;
        if ((phase_reg inside {[PH_TAG:PH_BITS]}) && (fmt_rem_reg != 32'd0))
        begin
            fmt_rem_next = fmt_rem_reg - 32'd1;
        end

        // Chunk header collection: four id bytes, then four size bytes.
        hdr_tag   = (cnt_reg == 3'd0) ? 32'd0 : tag_reg;
        hdr_shift = (cnt_reg == 3'd0) ? 32'd0 : shift_reg;
        if (cnt_reg < 3'd4)
        begin
            hdr_tag = put_byte(hdr_tag, b, cnt_reg[1:0]);
        end
        else
        begin
            hdr_shift = put_byte(hdr_shift, b, cnt_reg[1:0]);
        end
        hdr_done = (cnt_reg == 3'd7);

        // Little-endian field collection.
        fc          = cnt_reg[1:0];
        fld_shift   = put_byte((fc == 2'd0) ? 32'd0 : shift_reg, b, fc);
        fld_cnt_inc = {1'b0, fc} + 3'd1;

        skip_dec = skip_reg - 32'd1;
        pay_dec  = pay_rem_reg - 32'd1;

        ch_ok   = (chan_reg == CHAN_MONO) || (chan_reg == CHAN_STEREO);
        bits_ok = (fld_shift == BITS_8) || (fld_shift == BITS_16);

        case (phase_reg)
            PH_RIFF_HDR, PH_FMT_HDR, PH_DATA_HDR:
            begin
                tag_next   = hdr_tag;
                shift_next = hdr_shift;
                cnt_next   = hdr_done ? 3'd0 : cnt_reg + 3'd1;
                if (hdr_done)
                begin
                    if (phase_reg == PH_RIFF_HDR && hdr_tag == TAG_RIFF)
                    begin
                        phase_next = PH_WAVE;
                    end
                    else if (phase_reg == PH_FMT_HDR && hdr_tag == TAG_FMT)
                    begin
                        fmt_rem_next = hdr_shift;
                        phase_next   = PH_TAG;
                    end
                    else if (phase_reg == PH_DATA_HDR && hdr_tag == TAG_DATA)
                    begin
                        pay_rem_next      = hdr_shift;
                        res_valid         = 1'b1;
                        res.kind          = KIND_HEADER;
                        res.sample_format = format_reg;
                        res.rate_hz       = rate_reg;
                        res.data_size     = hdr_shift;
                        phase_next = (hdr_shift != 32'd0) ? PH_PAYLOAD : PH_DONE;
                    end
                    else
                    begin
                        // Unknown chunk: skip its body, if it has one.
                        skip_next = hdr_shift;
                        if (hdr_shift != 32'd0)
                        begin
                            phase_next = (phase_reg == PH_RIFF_HDR) ? PH_RIFF_SKIP :
                                         (phase_reg == PH_FMT_HDR)  ? PH_FMT_SKIP :
                                                                      PH_DATA_SKIP;
                        end
                    end
                end
            end
            PH_RIFF_SKIP, PH_FMT_SKIP, PH_DATA_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = (phase_reg == PH_RIFF_SKIP) ? PH_RIFF_HDR :
                                 (phase_reg == PH_FMT_SKIP)  ? PH_FMT_HDR :
                                                               PH_DATA_HDR;
                end
            end
            PH_WAVE, PH_RATE:
            begin
                shift_next = fld_shift;
                cnt_next   = (fc == 2'd3) ? 3'd0 : fld_cnt_inc;
                if (fc == 2'd3)
                begin
                    if (phase_reg == PH_RATE)
                    begin
                        rate_next  = fld_shift;
                        phase_next = PH_AVG;
                    end
                    else if (fld_shift == TAG_WAVE)
                    begin
                        phase_next = PH_FMT_HDR;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_REJECT;
                        res.error_code = ERR_NOT_WAVE;
                        phase_next     = PH_DONE;
                    end
                end
            end
            PH_TAG, PH_CHAN, PH_BITS:
            begin
                shift_next = fld_shift;
                cnt_next   = (fc != 2'd0) ? 3'd0 : fld_cnt_inc;
                if (fc != 2'd0)
                begin
                    if (phase_reg == PH_CHAN)
                    begin
                        chan_next  = fld_shift[15:0];
                        phase_next = PH_RATE;
                    end
                    else if (phase_reg == PH_TAG)
                    begin
                        if (fld_shift == FMT_PCM)
                        begin
                            phase_next = PH_CHAN;
                        end
                        else
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_REJECT;
                            res.error_code = ERR_NOT_PCM;
                            phase_next     = PH_DONE;
                        end
                    end
                    else if (ch_ok && bits_ok)
                    begin
                        format_next = {chan_reg == CHAN_STEREO, fld_shift == BITS_16};
                        phase_next  = (fmt_rem_next != 32'd0) ? PH_FMT_TAIL : PH_DATA_HDR;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_REJECT;
                        res.error_code = ERR_UNSUPPORTED;
                        phase_next     = PH_DONE;
                    end
                end
            end
            PH_AVG:
            begin
                if (cnt_reg >= AVG_LAST)
                begin
                    cnt_next   = 3'd0;
                    phase_next = PH_BITS;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_FMT_TAIL:
            begin
                fmt_rem_next = fmt_rem_reg - 32'd1;
                if (fmt_rem_next == 32'd0)
                begin
                    phase_next = PH_DATA_HDR;
                end
            end
            PH_PAYLOAD:
            begin
                pay_rem_next     = pay_dec;
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = b;
                res.last_payload = (pay_dec == 32'd0) || eos;
                if (pay_dec == 32'd0)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        // End of stream: report an unfinished header, then start over.
        if (eos)
        begin
            if (!res_valid && (phase_next < PH_PAYLOAD))
            begin
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = KIND_REJECT;
                res.error_code = ERR_EARLY_END;
            end
            phase_next = PH_RIFF_HDR;
            cnt_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RIFF_HDR;
            cnt_reg     <= 3'd0;
            shift_reg   <= 32'd0;
            tag_reg     <= 32'd0;
            skip_reg    <= 32'd0;
            fmt_rem_reg <= 32'd0;
            chan_reg    <= 16'd0;
            rate_reg    <= 32'd0;
            format_reg  <= 2'd0;
            pay_rem_reg <= 32'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            shift_reg   <= shift_next;
            tag_reg     <= tag_next;
            skip_reg    <= skip_next;
            fmt_rem_reg <= fmt_rem_next;
            chan_reg    <= chan_next;
            rate_reg    <= rate_next;
            format_reg  <= format_next;
            pay_rem_reg <= pay_rem_next;
        end
    end

endmodule

`default_nettype wire

// File: design/wavhp_queue.sv
// Back end: short result queue that presents the oldest result request.
`default_nettype none

module wavhp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire wavhp_pkg::result_t wr_data,
    input  wire logic               rd_en,
    output wavhp_pkg::result_t      rd_data,
    output logic                    full,
    output logic                    empty
);
    import wavhp_pkg::*;

    localparam logic [QUEUE_PTR_W-1:0] LAST_SLOT = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

    result_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/wav_header_parser.sv
// Top level of the WAV header parser: parser front end and result queue.
`default_nettype none

// The block reads a WAV file one byte per clock and reports what it finds.
// It walks the RIFF chunk list, checks the WAVE id, skips unknown chunks by
// their little-endian size, and reads the fmt chunk, accepting only PCM with
// one or two channels at 8 or 16 bits; bytes of a fmt chunk beyond its first
// 16 are skipped. When the data chunk header arrives it issues one header
// request (format, sample rate, data size) and then passes up to data-size
// payload bytes, one request each, with last_payload on the final one. An
// error issues one reject request and the rest of the stream is ignored; a
// byte with end_of_stream set ends the file and the parser starts over,
// rejecting with the early-end code if the header was left unfinished. Each
// byte is handled directly by the parser state machine, so the input side
// sustains one byte per clock while the queue is not full. Results go
// through a four-entry queue, and full rises only when it holds four results
// nobody has popped; the oldest unpopped result is shown on the result ports.

module wav_header_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire wavhp_pkg::item_t   item,
    input  wire logic               pop,
    output logic                    empty,
    output wavhp_pkg::result_t      result
);
    import wavhp_pkg::*;

    logic    step;
    logic    res_valid;
    result_t res;

    // A byte is taken whenever there is room for the result it may cause.
    assign step = push && !full;

    wavhp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    wavhp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (step && res_valid),
        .wr_data (res),
        .rd_en   (pop && !empty),
        .rd_data (result),
        .full    (full),
        .empty   (empty)
    );

endmodule

`default_nettype wire
